@@ sv/vcm_pkg.sv @@
// package for the velocity command mux: payload types, codes and defaults
package vcm_pkg;

    localparam int VEL_WIDTH_DEFAULT   = 16;
    localparam int AGE_WIDTH_DEFAULT   = 16;
    localparam int NUM_SOURCES_DEFAULT = 4;

    localparam int FIELD_WIDTH   = 16;
    localparam int LIMIT_WIDTH   = 15;
    localparam int TMO_WIDTH     = 16;
    localparam int PERIOD_WIDTH  = 16;
    localparam int SLOT_WIDTH    = 3;
    localparam int NUM_SLOTS     = 4;
    localparam int CFG_WIDTH     = 64;
    localparam int CFG_IDX_WIDTH = 3;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_ESTOP = 2'd1;
    localparam logic [1:0] KIND_MODE  = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    localparam logic [2:0] MODE_STOP = 3'd0;
    localparam logic [2:0] MODE_WEB  = 3'd1;
    localparam logic [2:0] MODE_AUTO = 3'd5;

    localparam logic [3:0] CODE_ESTOP    = 4'd0;
    localparam logic [3:0] CODE_STOP     = 4'd1;
    localparam logic [3:0] CODE_TIMEOUT  = 4'd2;
    localparam logic [3:0] CODE_SRC_BASE = 4'd3;
    localparam logic [3:0] CODE_ANN_BASE = 4'd7;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_FORWARD    = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_BACKWARD   = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MAX_TURN       = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SOURCE_TMO     = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_OUTPUT_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRIORITY_ORDER = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WEB_SETS_MODE  = 3'd6;

    localparam logic [LIMIT_WIDTH-1:0]       RST_MAX_FORWARD  = 15'd819;
    localparam logic [LIMIT_WIDTH-1:0]       RST_MAX_BACKWARD = 15'd328;
    localparam logic [LIMIT_WIDTH-1:0]       RST_MAX_TURN     = 15'd2867;
    localparam logic [4*TMO_WIDTH-1:0]       RST_SOURCE_TMO   = 64'd225183417375130400;
    localparam logic [PERIOD_WIDTH-1:0]      RST_OUTPUT_PERIOD = 16'd50;
    localparam logic [NUM_SLOTS*SLOT_WIDTH-1:0] RST_PRIORITY_ORDER = 12'd1665;

    localparam logic [SLOT_WIDTH-1:0] DEFAULT_ORDER [NUM_SLOTS] = '{3'd1, 3'd0, 3'd2, 3'd3};

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         source;
        logic signed [15:0] linear_in;
        logic signed [15:0] angular_in;
        logic               stop_flag;
        logic [2:0]         mode_code;
    } t_in_req;

    typedef struct packed {
        logic               has_twist;
        logic signed [15:0] linear_out;
        logic signed [15:0] angular_out;
        logic [3:0]         active_code;
    } t_out_req;

endpackage

@@ sv/velocity_command_mux.sv @@
// velocity command mux top level: source store, age timers, selection and result register
//
// input channel i_in_valid / o_in_ready carries one request: a velocity command from
// a source, an estop event, a mode command or a tick. output channel o_out_valid /
// i_out_ready carries results: velocity with an active code, or a mode announcement.
// every request updates state in the cycle it is accepted; a request that gives a
// result presents it on the output register in the cycle after acceptance.
// throughput is one request per cycle: ready is high while the output register is
// empty or being drained, so a stalled receiver holds back only the input channel.
// the freshness check of all sources and the priority search run in parallel in the
// accepting cycle, so the selection at a tick sees the ages after that tick.
// reset (synchronous, active low) restores the register defaults, stop mode, estop
// off, no command seen from any source, all ages and the period counter at zero,
// and an empty output register.
// the configuration port writes one register per cycle at i_cfg_we, no read-back.
module velocity_command_mux #(
    parameter int NUM_SOURCES = vcm_pkg::NUM_SOURCES_DEFAULT,
    parameter int VEL_WIDTH   = vcm_pkg::VEL_WIDTH_DEFAULT,
    parameter int AGE_WIDTH   = vcm_pkg::AGE_WIDTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  vcm_pkg::t_in_req                    i_in_req,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output vcm_pkg::t_out_req                   o_out_req,
    input  logic                                i_cfg_we,
    input  logic [vcm_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  logic [vcm_pkg::CFG_WIDTH-1:0]       i_cfg_data
);
    import vcm_pkg::*;

    localparam int CW     = ((VEL_WIDTH > FIELD_WIDTH) ? VEL_WIDTH : FIELD_WIDTH) + 1;
    localparam int AW_CMP = (AGE_WIDTH > TMO_WIDTH) ? AGE_WIDTH : TMO_WIDTH;
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

    // configuration
    logic [LIMIT_WIDTH-1:0]            r_max_forward;
    logic [LIMIT_WIDTH-1:0]            r_max_backward;
    logic [LIMIT_WIDTH-1:0]            r_max_turn;
    logic [4*TMO_WIDTH-1:0]            r_source_tmo;
    logic [PERIOD_WIDTH-1:0]           r_output_period;
    logic [NUM_SLOTS*SLOT_WIDTH-1:0]   r_priority_order;
    logic                              r_web_sets_mode;

    // state
    logic [2:0]                        r_mode;
    logic                              r_estop;
    logic signed [VEL_WIDTH-1:0]       r_lin [NUM_SOURCES];
    logic signed [VEL_WIDTH-1:0]       r_ang [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]            r_seen;
    logic [AGE_WIDTH-1:0]              r_age [NUM_SOURCES];
    logic [PERIOD_WIDTH-1:0]           r_pc;
    logic                              r_out_valid;
    t_out_req                          r_out_req;

    logic                              w_in_acc;
    logic signed [VEL_WIDTH-1:0]       w_cmd_lin;
    logic signed [VEL_WIDTH-1:0]       w_cmd_ang;
    logic [AGE_WIDTH-1:0]              w_tick_age [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]            w_fresh;
    logic [7:0]                        w_fresh8;
    logic [PERIOD_WIDTH-1:0]           w_pc_inc;
    logic [PERIOD_WIDTH-1:0]           w_period_eff;
    logic                              w_period_hit;

    logic                              w_any_slot;
    logic                              w_found;
    logic [SLOT_WIDTH-1:0]             w_auto_src;
    logic [SLOT_WIDTH-1:0]             w_fixed_src;
    logic [SLOT_WIDTH-1:0]             w_sel;
    logic signed [VEL_WIDTH-1:0]       w_pick_lin;
    logic signed [VEL_WIDTH-1:0]       w_pick_ang;
    logic signed [CW-1:0]              w_lin_x;
    logic signed [CW-1:0]              w_ang_x;
    logic signed [CW-1:0]              w_lin_lo;
    logic signed [CW-1:0]              w_lin_hi;
    logic signed [CW-1:0]              w_ang_hi;
    logic signed [CW-1:0]              w_lin_c;
    logic signed [CW-1:0]              w_ang_c;
    t_out_req                          w_sel_req;

    logic [2:0]                        n_mode;
    logic                              n_estop;
    logic                              n_out_valid;
    t_out_req                          n_out_req;
    logic                              w_has_result;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    assign w_cmd_lin = VEL_WIDTH'(i_in_req.linear_in);
    assign w_cmd_ang = VEL_WIDTH'(i_in_req.angular_in);

    // ages after a tick and freshness against them
    genvar g;
    generate
        for (g = 0; g < NUM_SOURCES; g++) begin : g_src
            logic [TMO_WIDTH-1:0] w_tmo;
            assign w_tmo = r_source_tmo[TMO_WIDTH*(g % 4) +: TMO_WIDTH];
            assign w_tick_age[g] = (r_seen[g] && r_age[g] != AGE_MAX) ?
                                   r_age[g] + 1'b1 : r_age[g];
            assign w_fresh[g] = r_seen[g] &&
                                (AW_CMP'(w_tick_age[g]) <= AW_CMP'(w_tmo));
        end
    endgenerate

    assign w_fresh8     = 8'(w_fresh);
    assign w_pc_inc     = r_pc + 1'b1;
    assign w_period_eff = (r_output_period == '0) ? PERIOD_WIDTH'(1) : r_output_period;
    assign w_period_hit = w_pc_inc >= w_period_eff;

    // priority search for auto mode
    always_comb begin
        logic [SLOT_WIDTH-1:0] slot;
        w_any_slot = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot = r_priority_order[SLOT_WIDTH*i +: SLOT_WIDTH];
            if (4'(slot) < 4'(NUM_SOURCES)) begin
                w_any_slot = 1'b1;
            end
        end
        w_found    = 1'b0;
        w_auto_src = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot = w_any_slot ? r_priority_order[SLOT_WIDTH*i +: SLOT_WIDTH]
                              : DEFAULT_ORDER[i];
            if (!w_found && 4'(slot) < 4'(NUM_SOURCES) && w_fresh8[slot]) begin
                w_found    = 1'b1;
                w_auto_src = slot;
            end
        end
    end

    assign w_fixed_src = r_mode - 3'd1;
    assign w_sel       = (r_mode == MODE_AUTO) ? w_auto_src : w_fixed_src;

    always_comb begin
        w_pick_lin = '0;
        w_pick_ang = '0;
        for (int j = 0; j < NUM_SOURCES; j++) begin
            if (SLOT_WIDTH'(j) == w_sel) begin
                w_pick_lin = r_lin[j];
                w_pick_ang = r_ang[j];
            end
        end
    end

    // clamp to the configured limits
    assign w_lin_x  = CW'(w_pick_lin);
    assign w_ang_x  = CW'(w_pick_ang);
    assign w_lin_lo = -CW'($signed({1'b0, r_max_backward}));
    assign w_lin_hi = CW'($signed({1'b0, r_max_forward}));
    assign w_ang_hi = CW'($signed({1'b0, r_max_turn}));
    assign w_lin_c  = (w_lin_x < w_lin_lo) ? w_lin_lo :
                      (w_lin_x > w_lin_hi) ? w_lin_hi : w_lin_x;
    assign w_ang_c  = (w_ang_x < -w_ang_hi) ? -w_ang_hi :
                      (w_ang_x > w_ang_hi) ? w_ang_hi : w_ang_x;

    always_comb begin
        w_sel_req.has_twist   = 1'b1;
        w_sel_req.linear_out  = '0;
        w_sel_req.angular_out = '0;
        w_sel_req.active_code = CODE_TIMEOUT;
        if (r_estop) begin
            w_sel_req.active_code = CODE_ESTOP;
        end else if (r_mode == MODE_STOP) begin
            w_sel_req.active_code = CODE_STOP;
        end else if (r_mode == MODE_AUTO) begin
            if (w_found) begin
                w_sel_req.linear_out  = 16'(w_lin_c);
                w_sel_req.angular_out = 16'(w_ang_c);
                w_sel_req.active_code = CODE_SRC_BASE + 4'(w_sel);
            end
        end else if (4'(w_fixed_src) >= 4'(NUM_SOURCES)) begin
            w_sel_req.active_code = CODE_STOP;
        end else if (w_fresh8[w_fixed_src]) begin
            if (w_lin_c == '0 && w_ang_c == '0) begin
                w_sel_req.active_code = CODE_ANN_BASE + 4'(r_mode);
            end else begin
                w_sel_req.linear_out  = 16'(w_lin_c);
                w_sel_req.angular_out = 16'(w_ang_c);
                w_sel_req.active_code = CODE_SRC_BASE + 4'(w_sel);
            end
        end
    end

    // request decode
    always_comb begin
        n_mode                = r_mode;
        n_estop               = r_estop;
        w_has_result          = 1'b0;
        n_out_req.has_twist   = 1'b1;
        n_out_req.linear_out  = '0;
        n_out_req.angular_out = '0;
        n_out_req.active_code = CODE_ESTOP;
        case (i_in_req.kind)
            KIND_CMD: begin
                if (4'(i_in_req.source) < 4'(NUM_SOURCES) && i_in_req.source == 2'd0 &&
                    r_web_sets_mode && (w_cmd_lin != '0 || w_cmd_ang != '0)) begin
                    n_mode = MODE_WEB;
                end
            end
            KIND_ESTOP: begin
                n_estop = i_in_req.stop_flag;
                if (i_in_req.stop_flag) begin
                    n_mode       = MODE_STOP;
                    w_has_result = 1'b1;
                end
            end
            KIND_MODE: begin
                n_mode = (i_in_req.mode_code > MODE_AUTO) ? MODE_STOP : i_in_req.mode_code;
                w_has_result          = 1'b1;
                n_out_req.has_twist   = 1'b0;
                n_out_req.active_code = CODE_ANN_BASE + 4'(n_mode);
            end
            KIND_TICK: begin
                if (w_period_hit) begin
                    w_has_result = 1'b1;
                    n_out_req    = w_sel_req;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_in_acc && w_has_result) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_forward    <= RST_MAX_FORWARD;
            r_max_backward   <= RST_MAX_BACKWARD;
            r_max_turn       <= RST_MAX_TURN;
            r_source_tmo     <= RST_SOURCE_TMO;
            r_output_period  <= RST_OUTPUT_PERIOD;
            r_priority_order <= RST_PRIORITY_ORDER;
            r_web_sets_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_FORWARD:    r_max_forward    <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_MAX_BACKWARD:   r_max_backward   <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_MAX_TURN:       r_max_turn       <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_SOURCE_TMO:     r_source_tmo     <= i_cfg_data[4*TMO_WIDTH-1:0];
                CFG_OUTPUT_PERIOD:  r_output_period  <= i_cfg_data[PERIOD_WIDTH-1:0];
                CFG_PRIORITY_ORDER: r_priority_order <=
                                        i_cfg_data[NUM_SLOTS*SLOT_WIDTH-1:0];
                CFG_WEB_SETS_MODE:  r_web_sets_mode  <= i_cfg_data[0];
                default: begin
                    r_web_sets_mode <= r_web_sets_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STOP;
            r_estop     <= 1'b0;
            r_seen      <= '0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_lin[i] <= '0;
                r_ang[i] <= '0;
                r_age[i] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (w_in_acc) begin
                r_mode  <= n_mode;
                r_estop <= n_estop;
                if (i_in_req.kind == KIND_CMD) begin
                    for (int i = 0; i < NUM_SOURCES; i++) begin
                        if (2'(i) == i_in_req.source && i < 4) begin
                            r_lin[i]  <= w_cmd_lin;
                            r_ang[i]  <= w_cmd_ang;
                            r_seen[i] <= 1'b1;
                            r_age[i]  <= '0;
                        end
                    end
                end
                if (i_in_req.kind == KIND_TICK) begin
                    r_pc <= w_period_hit ? '0 : w_pc_inc;
                    for (int i = 0; i < NUM_SOURCES; i++) begin
                        r_age[i] <= w_tick_age[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_has_result) begin
            r_out_req <= n_out_req;
        end
    end

    // checks
    generate
        for (g = 0; g < NUM_SOURCES; g++) begin : g_chk
            a_unseen_age_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                !r_seen[g] |-> r_age[g] == '0)
                else $error("age moved on a source that never sent a command");
        end
    endgenerate

    a_estop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_req.kind == KIND_ESTOP && i_in_req.stop_flag |=>
        o_out_valid && o_out_req.active_code == CODE_ESTOP && r_mode == MODE_STOP)
        else $error("estop request did not give an estop result");

    a_estop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.active_code == CODE_ESTOP |->
        o_out_req.linear_out == '0 && o_out_req.angular_out == '0)
        else $error("nonzero velocity under estop");

    a_announce_no_twist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_req.has_twist |-> o_out_req.active_code >= CODE_ANN_BASE)
        else $error("result without velocity carries a selection code");

    a_tick_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_req.kind == KIND_TICK && w_period_hit |=>
        o_out_valid && o_out_req.has_twist && r_pc == '0)
        else $error("period expiry gave no selection result");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for velocity_command_mux: directed table, random phases, scoreboard
module testbench;
    import vcm_pkg::*;

    localparam logic [1:0] SRC_WEB      = 2'd0;
    localparam logic [1:0] SRC_KEYBOARD = 2'd1;
    localparam logic [1:0] SRC_FOLLOW   = 2'd2;
    localparam logic [1:0] SRC_NAV      = 2'd3;

    localparam logic [2:0] MODE_KEYBOARD    = 3'd2;
    localparam logic [2:0] MODE_FOLLOW      = 3'd3;
    localparam logic [2:0] MODE_NAV         = 3'd4;
    localparam logic [2:0] MODE_MAP_STOP_LO = 3'd6;
    localparam logic [2:0] MODE_MAP_STOP_HI = 3'd7;

    localparam logic signed [15:0] VEL_MAX = 16'sh7FFF;
    localparam logic signed [15:0] VEL_MIN = 16'sh8000;

    localparam int NUM_PHASES      = 10;
    localparam int PHASE_ITEMS     = 135;
    localparam int SLOW_ITEMS      = 40;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TIMEOUT_NS      = 5_000_000;

    typedef struct {
        logic [LIMIT_WIDTH-1:0]           fwd;
        logic [LIMIT_WIDTH-1:0]           bwd;
        logic [LIMIT_WIDTH-1:0]           turn;
        logic [4*TMO_WIDTH-1:0]           tmo;
        logic [PERIOD_WIDTH-1:0]          period;
        logic [NUM_SLOTS*SLOT_WIDTH-1:0]  prio;
        logic                             web;
    } t_cfg_set;

    typedef struct {
        t_in_req  req;
        bit       typed;
        bit       has_res;
        t_out_req res;
    } t_dir_row;

    localparam t_out_req NO_RESULT = '0;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    t_in_req                  i_in_req = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b1;
    t_out_req                 o_out_req;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_WIDTH-1:0]     i_cfg_data = '0;

    velocity_command_mux DUT (.*);

    // mirrored mux state and registers
    t_cfg_set mux_cfg = '{RST_MAX_FORWARD, RST_MAX_BACKWARD, RST_MAX_TURN, RST_SOURCE_TMO,
                          RST_OUTPUT_PERIOD, RST_PRIORITY_ORDER, 1'b0};
    logic [2:0]        mux_mode = MODE_STOP;
    bit                mux_estop = 1'b0;
    logic signed [15:0] mux_lin [NUM_SOURCES_DEFAULT] = '{default: '0};
    logic signed [15:0] mux_ang [NUM_SOURCES_DEFAULT] = '{default: '0};
    bit                mux_seen [NUM_SOURCES_DEFAULT] = '{default: 1'b0};
    logic [15:0]       mux_age [NUM_SOURCES_DEFAULT] = '{default: '0};
    logic [15:0]       mux_count = '0;

    t_out_req pending_out [$];
    t_out_req want;
    t_dir_row dir_tab [$];
    int       mismatches = 0;
    bit       idle_on = 1'b1;
    bit       hold_off = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic t_in_req make_request(logic [1:0] k, logic [1:0] s,
                                             logic signed [15:0] l, logic signed [15:0] a,
                                             logic f, logic [2:0] m);
        t_in_req r;
        r.kind       = k;
        r.source     = s;
        r.linear_in  = l;
        r.angular_in = a;
        r.stop_flag  = f;
        r.mode_code  = m;
        return r;
    endfunction

    function automatic t_out_req make_result(logic tw, logic signed [15:0] l,
                                             logic signed [15:0] a, logic [3:0] c);
        t_out_req r;
        r.has_twist   = tw;
        r.linear_out  = l;
        r.angular_out = a;
        r.active_code = c;
        return r;
    endfunction

    function automatic void add_row(input t_dir_row row);
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    function automatic bit src_fresh(int s);
        return mux_seen[s] && (mux_age[s] <= mux_cfg.tmo[TMO_WIDTH*s +: TMO_WIDTH]);
    endfunction

    function automatic t_out_req clamped_twist(int s, bit announce_zero);
        int lin;
        int ang;
        lin = mux_lin[s];
        ang = mux_ang[s];
        if (lin < -int'(mux_cfg.bwd)) lin = -int'(mux_cfg.bwd);
        if (lin > int'(mux_cfg.fwd)) lin = int'(mux_cfg.fwd);
        if (ang < -int'(mux_cfg.turn)) ang = -int'(mux_cfg.turn);
        if (ang > int'(mux_cfg.turn)) ang = int'(mux_cfg.turn);
        if (announce_zero && lin == 0 && ang == 0)
            return make_result(1'b1, '0, '0, CODE_ANN_BASE + mux_mode);
        return make_result(1'b1, lin[15:0], ang[15:0], CODE_SRC_BASE + 4'(s));
    endfunction

    function automatic t_out_req mux_select();
        bit any;
        int s;
        int i;
        if (mux_estop) return make_result(1'b1, '0, '0, CODE_ESTOP);
        if (mux_mode == MODE_STOP) return make_result(1'b1, '0, '0, CODE_STOP);
        if (mux_mode == MODE_AUTO) begin
            any = 1'b0;
            for (i = 0; i < NUM_SLOTS; i++)
                if (mux_cfg.prio[SLOT_WIDTH*i +: SLOT_WIDTH] < NUM_SOURCES_DEFAULT) any = 1'b1;
            for (i = 0; i < NUM_SLOTS; i++) begin
                s = any ? int'(mux_cfg.prio[SLOT_WIDTH*i +: SLOT_WIDTH]) : int'(DEFAULT_ORDER[i]);
                if (s < NUM_SOURCES_DEFAULT && src_fresh(s)) return clamped_twist(s, 1'b0);
            end
            return make_result(1'b1, '0, '0, CODE_TIMEOUT);
        end
        s = int'(mux_mode) - 1;
        if (src_fresh(s)) return clamped_twist(s, 1'b1);
        return make_result(1'b1, '0, '0, CODE_TIMEOUT);
    endfunction

    function automatic void mux_step(input t_in_req r, output bit got, output t_out_req res);
        logic [15:0] per;
        int i;
        got = 1'b0;
        res = NO_RESULT;
        case (r.kind)
            KIND_CMD: begin
                mux_lin[r.source]  = r.linear_in;
                mux_ang[r.source]  = r.angular_in;
                mux_seen[r.source] = 1'b1;
                mux_age[r.source]  = '0;
                if (r.source == SRC_WEB && mux_cfg.web && (r.linear_in != 0 || r.angular_in != 0))
                    mux_mode = MODE_WEB;
            end
            KIND_ESTOP: begin
                mux_estop = r.stop_flag;
                if (r.stop_flag) begin
                    mux_mode = MODE_STOP;
                    got = 1'b1;
                    res = make_result(1'b1, '0, '0, CODE_ESTOP);
                end
            end
            KIND_MODE: begin
                mux_mode = (r.mode_code > MODE_AUTO) ? MODE_STOP : r.mode_code;
                got = 1'b1;
                res = make_result(1'b0, '0, '0, CODE_ANN_BASE + mux_mode);
            end
            default: begin
                for (i = 0; i < NUM_SOURCES_DEFAULT; i++)
                    if (mux_seen[i] && mux_age[i] != 16'hFFFF) mux_age[i]++;
                mux_count++;
                per = (mux_cfg.period == 0) ? 16'd1 : mux_cfg.period;
                if (mux_count >= per) begin
                    mux_count = '0;
                    got = 1'b1;
                    res = mux_select();
                end
            end
        endcase
    endfunction

    function automatic logic signed [15:0] pick_velocity();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return VEL_MAX;
            2: return VEL_MIN;
            3, 4: return 16'($urandom_range(0, 8000)) - 16'sd4000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_req random_request();
        logic [63:0] raw;
        int pick;
        t_in_req r;
        raw  = {$urandom, $urandom};
        r    = t_in_req'(raw[$bits(t_in_req)-1:0]);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            r.kind = KIND_TICK;
        end else if (pick < 80) begin
            r.kind       = KIND_CMD;
            r.linear_in  = pick_velocity();
            r.angular_in = pick_velocity();
        end else if (pick < 92) begin
            r.kind = KIND_MODE;
        end else begin
            r.kind      = KIND_ESTOP;
            r.stop_flag = ($urandom_range(0, 2) == 0);
        end
        return r;
    endfunction

    function automatic t_cfg_set random_cfg();
        t_cfg_set c;
        int i;
        c.fwd  = LIMIT_WIDTH'($urandom_range(0, 1) ? $urandom_range(0, 32767)
                                                  : $urandom_range(0, 4096));
        c.bwd  = LIMIT_WIDTH'($urandom_range(0, 1) ? $urandom_range(0, 32767)
                                                  : $urandom_range(0, 4096));
        c.turn = LIMIT_WIDTH'($urandom_range(0, 1) ? $urandom_range(0, 32767)
                                                  : $urandom_range(0, 4096));
        for (i = 0; i < 4; i++)
            c.tmo[TMO_WIDTH*i +: TMO_WIDTH] =
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        c.period = PERIOD_WIDTH'($urandom_range(0, 6));
        if ($urandom_range(0, 1)) begin
            c.prio = (NUM_SLOTS*SLOT_WIDTH)'($urandom_range(0, 4095));
        end else begin
            for (i = 0; i < NUM_SLOTS; i++)
                c.prio[SLOT_WIDTH*i +: SLOT_WIDTH] = SLOT_WIDTH'($urandom_range(0, 3));
        end
        c.web = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] d);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
    endtask

    task automatic cfg_apply(input t_cfg_set c);
        cfg_write(CFG_MAX_FORWARD, 64'(c.fwd));
        cfg_write(CFG_MAX_BACKWARD, 64'(c.bwd));
        cfg_write(CFG_MAX_TURN, 64'(c.turn));
        cfg_write(CFG_SOURCE_TMO, c.tmo);
        cfg_write(CFG_OUTPUT_PERIOD, 64'(c.period));
        cfg_write(CFG_PRIORITY_ORDER, 64'(c.prio));
        cfg_write(CFG_WEB_SETS_MODE, 64'(c.web));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mux_cfg = c;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic offer(input t_in_req r, input bit typed, input bit has_res,
                         input t_out_req typed_res);
        bit got;
        t_out_req p;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        mux_step(r, got, p);
        if (typed) begin
            if (has_res) pending_out.insert(pending_out.size(), typed_res);
        end else if (got) begin
            pending_out.insert(pending_out.size(), p);
        end
    endtask

    // output side: random stalls plus one long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_off = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_out.size() == 0) begin
                $error("unexpected result: active_code %0d", o_out_req.active_code);
                mismatches++;
            end else begin
                want = pending_out.pop_front();
                if (o_out_req.has_twist !== want.has_twist) begin
                    $error("has_twist expected %0d actual %0d", want.has_twist,
                           o_out_req.has_twist);
                    mismatches++;
                end
                if (o_out_req.linear_out !== want.linear_out) begin
                    $error("linear_out expected %0d actual %0d", want.linear_out,
                           o_out_req.linear_out);
                    mismatches++;
                end
                if (o_out_req.angular_out !== want.angular_out) begin
                    $error("angular_out expected %0d actual %0d", want.angular_out,
                           o_out_req.angular_out);
                    mismatches++;
                end
                if (o_out_req.active_code !== want.active_code) begin
                    $error("active_code expected %0d actual %0d", want.active_code,
                           o_out_req.active_code);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        t_cfg_set c;
        int p;
        int n;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part with a zero period, which acts as one
        c = mux_cfg;
        c.period = '0;
        cfg_apply(c);

        add_row('{make_request(KIND_TICK, SRC_NAV, VEL_MAX, VEL_MIN, 1'b1, MODE_AUTO),
                  1'b1, 1'b1, make_result(1'b1, '0, '0, CODE_STOP)});
        add_row('{make_request(KIND_MODE, SRC_WEB, '0, '0, 1'b0, MODE_AUTO),
                  1'b1, 1'b1, make_result(1'b0, '0, '0, CODE_ANN_BASE + MODE_AUTO)});
        add_row('{make_request(KIND_TICK, SRC_WEB, '0, '0, 1'b0, MODE_STOP),
                  1'b1, 1'b1, make_result(1'b1, '0, '0, CODE_TIMEOUT)});
        add_row('{make_request(KIND_CMD, SRC_KEYBOARD, VEL_MAX, VEL_MIN, 1'b0,
                               MODE_STOP), 1'b1, 1'b0, NO_RESULT});
        add_row('{make_request(KIND_TICK, SRC_WEB, '0, '0, 1'b0, MODE_STOP),
                  1'b1, 1'b1, make_result(1'b1, 16'sd819, -16'sd2867,
                                          CODE_SRC_BASE + SRC_KEYBOARD)});
        add_row('{make_request(KIND_CMD, SRC_WEB, VEL_MIN, VEL_MAX, 1'b1,
                               MODE_MAP_STOP_HI), 1'b1, 1'b0, NO_RESULT});
        add_row('{make_request(KIND_TICK, SRC_WEB, '0, '0, 1'b0, MODE_STOP),
                  1'b0, 1'b0, NO_RESULT});
        add_row('{make_request(KIND_MODE, SRC_WEB, '0, '0, 1'b0, MODE_WEB),
                  1'b1, 1'b1, make_result(1'b0, '0, '0, CODE_ANN_BASE + MODE_WEB)});
        add_row('{make_request(KIND_TICK, SRC_WEB, '0, '0, 1'b0, MODE_STOP),
                  1'b1, 1'b1, make_result(1'b1, -16'sd328, 16'sd2867,
                                          CODE_SRC_BASE + SRC_WEB)});
        add_row('{make_request(KIND_CMD, SRC_WEB, '0, '0, 1'b0, MODE_STOP),
                  1'b0, 1'b0, NO_RESULT});
        add_row('{make_request(KIND_TICK, SRC_WEB, '0, '0, 1'b0, MODE_STOP),
                  1'b0, 1'b0, NO_RESULT});
        add_row('{make_request(KIND_MODE, SRC_WEB, '0, '0, 1'b0, MODE_MAP_STOP_LO),
                  1'b1, 1'b1, make_result(1'b0, '0, '0, CODE_ANN_BASE + MODE_STOP)});
        add_row('{make_request(KIND_MODE, SRC_WEB, '0, '0, 1'b0, MODE_MAP_STOP_HI),
                  1'b1, 1'b1, make_result(1'b0, '0, '0, CODE_ANN_BASE + MODE_STOP)});
        add_row('{make_request(KIND_MODE, SRC_WEB, '0, '0, 1'b0, MODE_KEYBOARD),
                  1'b1, 1'b1, make_result(1'b0, '0, '0,
                                          CODE_ANN_BASE + MODE_KEYBOARD)});
        add_row('{make_request(KIND_ESTOP, SRC_WEB, '0, '0, 1'b1, MODE_STOP),
                  1'b1, 1'b1, make_result(1'b1, '0, '0, CODE_ESTOP)});
        add_row('{make_request(KIND_TICK, SRC_WEB, '0, '0, 1'b0, MODE_STOP),
                  1'b1, 1'b1, make_result(1'b1, '0, '0, CODE_ESTOP)});
        add_row('{make_request(KIND_ESTOP, SRC_NAV, VEL_MAX, VEL_MAX, 1'b0,
                               MODE_MAP_STOP_HI), 1'b1, 1'b0, NO_RESULT});
        add_row('{make_request(KIND_TICK, SRC_WEB, '0, '0, 1'b0, MODE_STOP),
                  1'b1, 1'b1, make_result(1'b1, '0, '0, CODE_STOP)});
        add_row('{make_request(KIND_MODE, SRC_WEB, '0, '0, 1'b0, MODE_FOLLOW),
                  1'b1, 1'b1, make_result(1'b0, '0, '0, CODE_ANN_BASE + MODE_FOLLOW)});
        add_row('{make_request(KIND_TICK, SRC_WEB, '0, '0, 1'b0, MODE_STOP),
                  1'b1, 1'b1, make_result(1'b1, '0, '0, CODE_TIMEOUT)});
        add_row('{make_request(KIND_CMD, SRC_NAV, 16'sd100, -16'sd100, 1'b0,
                               MODE_STOP), 1'b1, 1'b0, NO_RESULT});
        add_row('{make_request(KIND_MODE, SRC_WEB, '0, '0, 1'b0, MODE_NAV),
                  1'b1, 1'b1, make_result(1'b0, '0, '0, CODE_ANN_BASE + MODE_NAV)});
        add_row('{make_request(KIND_TICK, SRC_WEB, '0, '0, 1'b0, MODE_STOP),
                  1'b0, 1'b0, NO_RESULT});

        foreach (dir_tab[i])
            offer(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].has_res, dir_tab[i].res);

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: c = '{'0, '0, '0, '0, 16'd1, '1, 1'b1};
                1: c = '{'1, '1, '1, '1, 16'd2, '0, 1'b0};
                default: c = random_cfg();
            endcase
            n = PHASE_ITEMS;
            if (p == 2) c.period = 16'd1;
            if (p == 3) begin
                c.period = '1;
                n = SLOW_ITEMS;
            end
            wait_drained();
            if (p == 2) hold_off = 1'b1;
            cfg_apply(c);
            idle_on = (p < NUM_PHASES - 2);
            repeat (n) offer(random_request(), 1'b0, 1'b0, NO_RESULT);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
